// ===== hdl/jdfp_pkg.sv =====
// ---------------------------------------------------------------------------
// jdfp_pkg
// Shared types, widths and constants of the joint distance feedrate planner.
// ---------------------------------------------------------------------------
package jdfp_pkg;

	localparam int COORD_W  = 24;
	localparam int RATE_W   = 16;
	localparam int FEED_W   = 16;
	localparam int NUM_AXES = 6;
	localparam int AX_W     = $clog2(NUM_AXES);

	// sum of six squares of COORD_W-bit magnitudes, padded to an even width
	localparam int SQ_W     = 2 * COORD_W;
	localparam int SUM_W    = SQ_W + 4;
	localparam int ROOT1_W  = SUM_W / 2;
	localparam int ROOT2_W  = ROOT1_W / 2;
	localparam int REM_W    = ROOT1_W + 2;
	localparam int STEP_W   = $clog2(ROOT1_W + 1);

	// rate = (base * fourth root) >> 5
	localparam int RATE_SHIFT = 5;
	localparam int PROD_W     = RATE_W + ROOT2_W;
	localparam int RAW_W      = PROD_W - RATE_SHIFT;

	// configuration port
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_BASE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MAX  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MIN  = 2'd2;

	localparam logic [RATE_W-1:0] BASE_RESET = RATE_W'(9600);
	localparam logic [RATE_W-1:0] MAX_RESET  = RATE_W'(40000);
	localparam logic [RATE_W-1:0] MIN_RESET  = RATE_W'(8000);

	typedef struct packed {
		logic signed [COORD_W-1:0] axis_x;
		logic signed [COORD_W-1:0] axis_y;
		logic signed [COORD_W-1:0] axis_z;
		logic signed [COORD_W-1:0] axis_b;
		logic signed [COORD_W-1:0] axis_c;
		logic signed [COORD_W-1:0] axis_e;
		logic                      ends_section;
		logic                      starts_section;
		logic                      path_end;
	} wp_t;

	typedef struct packed {
		logic [FEED_W-1:0] feed_out;
		logic              conflict_error;
		logic              run_last;
	} feed_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} sqrt_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sqrt_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SQR,
		ST_ACC,
		ST_R1_GO,
		ST_R1_WAIT,
		ST_R2_GO,
		ST_R2_WAIT,
		ST_MUL,
		ST_CLAMP,
		ST_OUT1,
		ST_OUT2
	} plan_state_t;

	// magnitude of the difference of two signed coordinates
	function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b);
		logic [COORD_W:0] d;
		logic [COORD_W:0] m;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		m = d[COORD_W] ? (~d + 1'b1) : d;
		return m[COORD_W-1:0];
	endfunction

endpackage

// ===== hdl/jdfp_isqrt.sv =====
// ---------------------------------------------------------------------------
// jdfp_isqrt
// Floored integer square root, two operand bits per cycle from the top down.
// ---------------------------------------------------------------------------
module jdfp_isqrt
	import jdfp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  sqrt_cmd_t          cmd,
	input  logic [SUM_W-1:0]   operand,
	output sqrt_stat_t         stat,
	output logic [ROOT1_W-1:0] root
);

	logic [SUM_W-1:0]   opnd_q;
	logic [REM_W-1:0]   rem_q;
	logic [ROOT1_W-1:0] root_q;
	logic [STEP_W-1:0]  cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [REM_W-1:0]   rem_sh;
	logic [REM_W-1:0]   trial;
	logic               fits;

	assign rem_sh = {rem_q[REM_W-3:0], opnd_q[SUM_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign fits   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand is consumed from the top, so n steps give the root of its top 2n bits
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			opnd_q <= operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			opnd_q <= {opnd_q[SUM_W-3:0], 2'b00};
			rem_q  <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT1_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign root      = root_q;

endmodule

// ===== hdl/joint_distance_feedrate_planner.sv =====
// ---------------------------------------------------------------------------
// joint_distance_feedrate_planner
// Feedrate of each six-axis waypoint from the joint distance to the next one.
// ---------------------------------------------------------------------------
//  channel    direction  handshake                    word
//  wp         in         wp_valid / wp_ready          wp_t: six axes, three flags
//  feed       out        feed_valid / feed_ready      feed_t: rate, error, last
//  apb        in         psel, penable, pwrite        base, max and min rate
//
// a distance waypoint runs six diff, square and add passes, squaring through the
// shared multiplier, then starts and waits on each of the two roots in turn, then
// multiplies, clamps, outputs one or two words and returns to idle
// a section end skips the distance work and goes straight to the clamp
// reset clears all control state at once; no clearing pass
// wp_ready is high only when idle; output states wait on feed_ready
// ---------------------------------------------------------------------------
module joint_distance_feedrate_planner
	import jdfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              wp_valid,
	output logic              wp_ready,
	input  wp_t               wp_data,
	output logic              feed_valid,
	input  logic              feed_ready,
	output feed_t             feed_data
);

	plan_state_t state_q;
	plan_state_t state_nx;

	logic [RATE_W-1:0] base_q;
	logic [RATE_W-1:0] max_q;
	logic [RATE_W-1:0] min_q;
	logic [REG_IDX_W-1:0] reg_idx;

	logic [COORD_W-1:0] held_q [NUM_AXES];
	logic [COORD_W-1:0] in_q   [NUM_AXES];
	logic [COORD_W-1:0] wp_axes [NUM_AXES];
	logic held_es_q;
	logic held_ss_q;
	logic have_held_q;
	logic halted_q;
	logic in_es_q;
	logic in_ss_q;
	logic in_pe_q;
	logic [RATE_W-1:0] last_rate_q;

	logic [AX_W-1:0]    ax_q;
	logic [COORD_W-1:0] d_q;
	logic [SQ_W-1:0]    sq_q;
	logic [SUM_W-1:0]   sum_q;
	logic [RAW_W-1:0]   rate_q;

	logic [RATE_W-1:0] res_feed_q;
	logic              res_err_q;
	logic              res_two_q;

	feed_t feed_q;
	logic  feed_valid_q;

	logic               wp_acc;
	logic               out_load;
	sqrt_cmd_t          sq_cmd;
	sqrt_stat_t         sq_stat;
	logic [SUM_W-1:0]   sq_opnd;
	logic [ROOT1_W-1:0] sq_root;

	logic [COORD_W-1:0] mul_a;
	logic [COORD_W-1:0] mul_b;
	logic [SQ_W-1:0]    mul_p;

	logic [RAW_W-1:0]  clamp_hi;
	logic [RAW_W-1:0]  clamp_lo;
	logic [RATE_W-1:0] clamped;

	// -----------------------------------------------------------------------
	// configuration
	// -----------------------------------------------------------------------
	assign reg_idx = paddr[ADDR_W-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
			max_q  <= MAX_RESET;
			min_q  <= MIN_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_BASE: base_q <= pwdata[RATE_W-1:0];
				REG_MAX:  max_q  <= pwdata[RATE_W-1:0];
				REG_MIN:  min_q  <= pwdata[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BASE: prdata = {{(DATA_W-RATE_W){1'b0}}, base_q};
			REG_MAX:  prdata = {{(DATA_W-RATE_W){1'b0}}, max_q};
			REG_MIN:  prdata = {{(DATA_W-RATE_W){1'b0}}, min_q};
			default:  prdata = '0;
		endcase
	end

	// -----------------------------------------------------------------------
	// shared units
	// -----------------------------------------------------------------------
	assign mul_p = mul_a * mul_b;

	jdfp_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (sq_cmd),
		.operand (sq_opnd),
		.stat    (sq_stat),
		.root    (sq_root)
	);

	assign wp_axes[0] = wp_data.axis_x;
	assign wp_axes[1] = wp_data.axis_y;
	assign wp_axes[2] = wp_data.axis_z;
	assign wp_axes[3] = wp_data.axis_b;
	assign wp_axes[4] = wp_data.axis_c;
	assign wp_axes[5] = wp_data.axis_e;

	// upper clamp first, lower clamp wins
	assign clamp_hi = (rate_q >= RAW_W'(max_q)) ? RAW_W'(max_q) : rate_q;
	assign clamp_lo = (clamp_hi <= RAW_W'(min_q)) ? RAW_W'(min_q) : clamp_hi;
	assign clamped  = clamp_lo[RATE_W-1:0];

	// -----------------------------------------------------------------------
	// sequencer
	// -----------------------------------------------------------------------
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (wp_valid) begin
					if (halted_q)
						state_nx = ST_IDLE;
					else if (!have_held_q)
						state_nx = wp_data.path_end ? ST_OUT1 : ST_IDLE;
					else if (held_es_q && held_ss_q)
						state_nx = ST_OUT1;
					else if (held_es_q)
						state_nx = ST_CLAMP;
					else
						state_nx = ST_DIFF;
				end
			end
			ST_DIFF:    state_nx = ST_SQR;
			ST_SQR:     state_nx = ST_ACC;
			ST_ACC:     state_nx = (ax_q == AX_W'(NUM_AXES - 1)) ? ST_R1_GO : ST_DIFF;
			ST_R1_GO:   state_nx = ST_R1_WAIT;
			ST_R1_WAIT: state_nx = sq_stat.done ? ST_R2_GO : ST_R1_WAIT;
			ST_R2_GO:   state_nx = ST_R2_WAIT;
			ST_R2_WAIT: state_nx = sq_stat.done ? ST_MUL : ST_R2_WAIT;
			ST_MUL:     state_nx = ST_CLAMP;
			ST_CLAMP:   state_nx = ST_OUT1;
			ST_OUT1: begin
				if (!feed_valid_q || feed_ready)
					state_nx = res_two_q ? ST_OUT2 : ST_IDLE;
			end
			ST_OUT2: begin
				if (!feed_valid_q || feed_ready)
					state_nx = ST_IDLE;
			end
			default:    state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		wp_ready     = 1'b0;
		out_load     = 1'b0;
		sq_cmd.start = 1'b0;
		sq_cmd.steps = STEP_W'(ROOT1_W);
		sq_opnd      = sum_q;
		mul_a        = d_q;
		mul_b        = d_q;
		case (state_q)
			ST_IDLE:  wp_ready = 1'b1;
			ST_R1_GO: sq_cmd.start = 1'b1;
			ST_R2_GO: begin
				sq_cmd.start = 1'b1;
				sq_cmd.steps = STEP_W'(ROOT2_W);
				sq_opnd      = {sq_root, {(SUM_W-ROOT1_W){1'b0}}};
			end
			ST_MUL: begin
				mul_a = {{(COORD_W-RATE_W){1'b0}}, base_q};
				mul_b = {{(COORD_W-ROOT2_W){1'b0}}, sq_root[ROOT2_W-1:0]};
			end
			ST_OUT1,
			ST_OUT2:  out_load = !feed_valid_q || feed_ready;
			default: ;
		endcase
	end

	assign wp_acc = wp_valid && wp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	// waypoint and rate state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_held_q <= 1'b0;
			held_es_q   <= 1'b0;
			held_ss_q   <= 1'b0;
			halted_q    <= 1'b0;
			last_rate_q <= '0;
		end else if (wp_acc && !halted_q) begin
			if (!have_held_q) begin
				if (wp_data.path_end) begin
					last_rate_q <= '0;
				end else begin
					have_held_q <= 1'b1;
					held_es_q   <= wp_data.ends_section;
					held_ss_q   <= wp_data.starts_section;
				end
			end else if (held_es_q && held_ss_q) begin
				halted_q <= 1'b1;
			end
		end else if (state_q == ST_CLAMP) begin
			if (in_pe_q) begin
				have_held_q <= 1'b0;
				held_es_q   <= 1'b0;
				held_ss_q   <= 1'b0;
				last_rate_q <= '0;
			end else begin
				held_es_q   <= in_es_q;
				held_ss_q   <= in_ss_q;
				last_rate_q <= clamped;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wp_acc) begin
			for (int i = 0; i < NUM_AXES; i++)
				in_q[i] <= wp_axes[i];
			in_es_q <= wp_data.ends_section;
			in_ss_q <= wp_data.starts_section;
			in_pe_q <= wp_data.path_end;
			ax_q    <= '0;
			sum_q   <= '0;
			rate_q  <= RAW_W'(last_rate_q);
			if (!have_held_q) begin
				res_feed_q <= last_rate_q;
				res_err_q  <= 1'b0;
				res_two_q  <= 1'b0;
				if (!wp_data.path_end) begin
					for (int i = 0; i < NUM_AXES; i++)
						held_q[i] <= wp_axes[i];
				end
			end else begin
				res_feed_q <= '0;
				res_err_q  <= 1'b1;
				res_two_q  <= 1'b0;
			end
		end
		case (state_q)
			ST_DIFF: d_q  <= abs_diff(held_q[ax_q], in_q[ax_q]);
			ST_SQR:  sq_q <= mul_p;
			ST_ACC: begin
				sum_q <= sum_q + {{(SUM_W-SQ_W){1'b0}}, sq_q};
				ax_q  <= ax_q + 1'b1;
			end
			ST_MUL:  rate_q <= mul_p[PROD_W-1:RATE_SHIFT];
			ST_CLAMP: begin
				res_feed_q <= clamped;
				res_err_q  <= 1'b0;
				res_two_q  <= in_pe_q;
				if (!in_pe_q) begin
					for (int i = 0; i < NUM_AXES; i++)
						held_q[i] <= in_q[i];
				end
			end
			default: ;
		endcase
	end

	// -----------------------------------------------------------------------
	// output word register
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			feed_valid_q <= 1'b0;
		else if (out_load)
			feed_valid_q <= 1'b1;
		else if (feed_ready)
			feed_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			feed_q.feed_out       <= res_feed_q;
			feed_q.conflict_error <= (state_q == ST_OUT1) && res_err_q;
			feed_q.run_last       <= (state_q == ST_OUT2) || !res_two_q;
		end
	end

	assign feed_valid = feed_valid_q;
	assign feed_data  = feed_q;

	// -----------------------------------------------------------------------
	// assertions
	// -----------------------------------------------------------------------
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		feed_valid && feed_data.conflict_error |-> feed_data.run_last)
		else $error("error word not marked as last");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		feed_valid && feed_data.conflict_error |-> feed_data.feed_out == '0)
		else $error("error word carries a nonzero rate");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt released without reset");

	a_root_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sq_stat.busy |-> (state_q == ST_R1_WAIT || state_q == ST_R2_WAIT))
		else $error("root unit busy outside a root wait");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Drives six-axis waypoints into the feedrate planner under random stalls on
// both sides, predicts each feed word and checks the words in order. Rate
// registers are rewritten over the apb port between phases while the block is idle.
// ---------------------------------------------------------------------------
module tb_top;
	import jdfp_pkg::*;

	localparam longint COORD_HI = (64'sd1 <<< (COORD_W - 1)) - 1;
	localparam longint COORD_LO = -COORD_HI - 1;

	class feedrate_tracker;
		feed_t due_feeds[$];
		int errors;
		logic [RATE_W-1:0] base_rate, max_rate, min_rate;
		logic signed [COORD_W-1:0] held_pos[NUM_AXES];
		logic held_end, held_start, have_held, halted;
		logic [RATE_W-1:0] last_rate;

		function new();
			base_rate = BASE_RESET;
			max_rate = MAX_RESET;
			min_rate = MIN_RESET;
			foreach (held_pos[i]) held_pos[i] = '0;
			held_end = 1'b0;
			held_start = 1'b0;
			have_held = 1'b0;
			halted = 1'b0;
			last_rate = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [RATE_W-1:0] value);
			case (idx)
				REG_BASE: base_rate = value;
				REG_MAX: max_rate = value;
				REG_MIN: min_rate = value;
				default: ;
			endcase
		endfunction

		function int pending();
			return due_feeds.size();
		endfunction

		function bit [63:0] floor_root(bit [63:0] v);
			bit [63:0] r, t;
			r = '0;
			for (int b = 31; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t * t <= v) r = t;
			end
			return r;
		endfunction

		function void due(logic [FEED_W-1:0] feed, logic err, logic fin);
			due_feeds.push_back(feed_t'{feed_out: feed, conflict_error: err, run_last: fin});
		endfunction

		function void take_waypoint(wp_t w);
			logic signed [COORD_W-1:0] pos[NUM_AXES];
			bit [63:0] dist_sq, sq, rate;
			longint delta;
			if (halted) return;
			pos = '{w.axis_x, w.axis_y, w.axis_z, w.axis_b, w.axis_c, w.axis_e};
			if (!have_held) begin
				if (w.path_end) begin
					due(last_rate, 1'b0, 1'b1);
					last_rate = '0;
				end else begin
					held_pos = pos;
					held_end = w.ends_section;
					held_start = w.starts_section;
					have_held = 1'b1;
				end
				return;
			end
			if (held_end && held_start) begin
				due('0, 1'b1, 1'b1);
				halted = 1'b1;
				return;
			end
			if (held_end) begin
				rate = last_rate;
			end else begin
				dist_sq = '0;
				for (int i = 0; i < NUM_AXES; i++) begin
					delta = longint'(held_pos[i]) - longint'(pos[i]);
					if (delta < 0) delta = -delta;
					sq = delta * delta;
					dist_sq = (dist_sq > ~sq) ? '1 : dist_sq + sq;
				end
				rate = (64'(base_rate) * floor_root(floor_root(dist_sq))) >> RATE_SHIFT;
			end
			// upper clamp first, so min wins when the two cross
			if (rate >= max_rate) rate = max_rate;
			if (rate <= min_rate) rate = min_rate;
			last_rate = rate[RATE_W-1:0];
			if (w.path_end) begin
				due(last_rate, 1'b0, 1'b0);
				due(last_rate, 1'b0, 1'b1);
				have_held = 1'b0;
				held_end = 1'b0;
				held_start = 1'b0;
				last_rate = '0;
			end else begin
				due(last_rate, 1'b0, 1'b1);
				held_pos = pos;
				held_end = w.ends_section;
				held_start = w.starts_section;
			end
		endfunction

		function void match_feed(feed_t got);
			feed_t want;
			if (due_feeds.size() == 0) begin
				$display("%0t feed word with none due: expected nothing, actual %h", $time, got);
				errors++;
				return;
			end
			want = due_feeds.pop_front();
			if (got.feed_out !== want.feed_out) begin
				$display("%0t feed_out: expected %0d, actual %0d", $time, want.feed_out,
					got.feed_out);
				errors++;
			end
			if (got.conflict_error !== want.conflict_error) begin
				$display("%0t conflict_error: expected %b, actual %b", $time,
					want.conflict_error, got.conflict_error);
				errors++;
			end
			if (got.run_last !== want.run_last) begin
				$display("%0t run_last: expected %b, actual %b", $time, want.run_last,
					got.run_last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic wp_valid;
	logic wp_ready;
	wp_t wp_data;
	logic feed_valid;
	logic feed_ready = 1'b0;
	feed_t feed_data;

	feedrate_tracker sb = new();
	logic signed [COORD_W-1:0] cur_pos[NUM_AXES];
	int snd_idle = 36;
	int rcv_idle = 81;

	joint_distance_feedrate_planner dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.wp_valid(wp_valid),
		.wp_ready(wp_ready),
		.wp_data(wp_data),
		.feed_valid(feed_valid),
		.feed_ready(feed_ready),
		.feed_data(feed_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		feed_ready <= ($urandom_range(99) >= rcv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && feed_valid && feed_ready) sb.match_feed(feed_data);
	end

	initial begin
		#4_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic signed [COORD_W-1:0] step_axis(logic signed [COORD_W-1:0] p);
		int span;
		longint delta, n;
		case ($urandom_range(9))
			0, 1: span = 0;
			2, 3: span = 15;
			4, 5, 6: span = 4095;
			7, 8: span = 65535;
			default: return COORD_W'($urandom);
		endcase
		delta = $urandom_range(span);
		if ($urandom_range(1)) delta = -delta;
		n = longint'(p) + delta;
		if (n > COORD_HI || n < COORD_LO) n = longint'(p) - delta;
		return n[COORD_W-1:0];
	endfunction

	function automatic wp_t wp_from_pos(bit ends, bit starts, bit is_last);
		wp_t w;
		w.axis_x = cur_pos[0];
		w.axis_y = cur_pos[1];
		w.axis_z = cur_pos[2];
		w.axis_b = cur_pos[3];
		w.axis_c = cur_pos[4];
		w.axis_e = cur_pos[5];
		w.ends_section = ends;
		w.starts_section = starts;
		w.path_end = is_last;
		return w;
	endfunction

	function automatic wp_t next_wp(bit ends, bit starts, bit is_last);
		foreach (cur_pos[i]) cur_pos[i] = step_axis(cur_pos[i]);
		return wp_from_pos(ends, starts, is_last);
	endfunction

	task automatic send_wp(wp_t w);
		if ($urandom_range(99) < snd_idle) begin
			wp_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle);
		end
		wp_valid <= 1'b1;
		wp_data <= w;
		do @(posedge clk); while (!wp_ready);
		sb.take_waypoint(w);
	endtask

	// hold the sender off until no feed word is due, then let the block settle
	task automatic drain(int settle);
		wp_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [RATE_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, value);
	endtask

	task automatic configure(logic [RATE_W-1:0] base_v, logic [RATE_W-1:0] ceil_v,
			logic [RATE_W-1:0] floor_v);
		drain(100);
		write_reg(REG_BASE, base_v);
		write_reg(REG_MAX, ceil_v);
		write_reg(REG_MIN, floor_v);
	endtask

	// well-formed path: a section end before the last waypoint is always followed by a section start
	task automatic send_path(int len);
		bit ends, starts;
		starts = ($urandom_range(4) == 0);
		for (int k = 0; k < len; k++) begin
			ends = !starts && ($urandom_range(6) == 0);
			send_wp(next_wp(ends, starts, k == len - 1));
			starts = ends;
		end
	endtask

	task automatic send_noise();
		wp_t w;
		w = next_wp(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom_range(3) == 0);
		// both flags held back would halt the block for good
		if (w.ends_section && w.starts_section) w.path_end = 1'b1;
		send_wp(w);
	endtask

	task automatic run_phase(int items);
		int sent, len;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(19) == 0) begin
				drain(0);
			end else if ($urandom_range(99) < 15) begin
				send_noise();
				sent++;
			end else begin
				len = $urandom_range(1, 12);
				send_path(len);
				sent += len;
			end
		end
	endtask

	initial begin
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		wp_valid = 1'b0;
		wp_data = '0;
		arst_n = 1'b0;
		foreach (cur_pos[i]) cur_pos[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone waypoint path repeats a zero rate
		send_wp(wp_from_pos(1'b0, 1'b0, 1'b1));
		send_wp(wp_from_pos(1'b0, 1'b0, 1'b0));
		cur_pos[0] = 1024;
		send_wp(wp_from_pos(1'b0, 1'b0, 1'b0));
		// zero distance falls to the lower clamp
		send_wp(wp_from_pos(1'b0, 1'b0, 1'b0));
		foreach (cur_pos[i]) cur_pos[i] = COORD_W'(COORD_LO);
		send_wp(wp_from_pos(1'b0, 1'b0, 1'b0));
		foreach (cur_pos[i]) cur_pos[i] = COORD_W'(COORD_HI);
		send_wp(wp_from_pos(1'b1, 1'b0, 1'b0));
		cur_pos[2] = '0;
		send_wp(wp_from_pos(1'b0, 1'b1, 1'b0));
		send_wp(next_wp(1'b0, 1'b0, 1'b1));
		// section end before any rate exists
		send_wp(next_wp(1'b1, 1'b0, 1'b0));
		send_wp(next_wp(1'b0, 1'b1, 1'b0));
		send_wp(next_wp(1'b0, 1'b0, 1'b1));
		// both flags on a last waypoint give no error
		send_wp(next_wp(1'b0, 1'b0, 1'b0));
		send_wp(next_wp(1'b1, 1'b1, 1'b1));
		send_wp(next_wp(1'b1, 1'b1, 1'b1));
		send_wp(next_wp(1'b0, 1'b0, 1'b0));
		send_wp(next_wp(1'b1, 1'b0, 1'b1));

		configure(16'd12000, 16'd50000, 16'd4000);
		run_phase(100);
		configure(16'd65535, 16'd65535, 16'd0);
		run_phase(100);
		snd_idle = 81;
		rcv_idle = 36;
		configure(16'd0, 16'd65535, 16'd0);
		run_phase(100);
		// max below min
		configure(16'd20000, 16'd10000, 16'd30000);
		run_phase(100);
		snd_idle = 0;
		rcv_idle = 0;
		configure(RATE_W'($urandom), RATE_W'($urandom), RATE_W'($urandom));
		run_phase(100);
		configure(RATE_W'($urandom_range(1, 65535)), RATE_W'($urandom_range(20000, 65535)),
			RATE_W'($urandom_range(0, 20000)));
		run_phase(100);

		// conflicting flags halt the block, so this comes last
		drain(100);
		send_wp(next_wp(1'b0, 1'b0, 1'b0));
		send_wp(next_wp(1'b1, 1'b1, 1'b0));
		send_wp(next_wp(1'b0, 1'b0, 1'b0));
		send_wp(next_wp(1'b0, 1'b0, 1'b0));
		send_wp(next_wp(1'b0, 1'b0, 1'b1));
		drain(200);

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

// ===== files.f =====
hdl/jdfp_pkg.sv
hdl/jdfp_isqrt.sv
hdl/joint_distance_feedrate_planner.sv
verif/tb_top.sv
